// ===== rtl/rr_pkg.sv =====
// rational reconstruction package: state encoding, status codes, datapath command types
// no dependencies
`timescale 1ns / 1ps

package rr_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned NUM_W  = 32;
  localparam int unsigned DEN_W  = 31;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned ADDR_W = 3;

  localparam logic [ADDR_W-1:0] ADDR_MODULUS = 3'd0;

  localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOFRAC = 2'd1;
  localparam logic [STAT_W-1:0] STAT_VERIFY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SQRT,
    ST_EUCLID_CHK,
    ST_EUCLID_DIV,
    ST_SIGN,
    ST_GCD_CHK,
    ST_GCD_DIV,
    ST_MUL,
    ST_FINAL,
    ST_OUT
  } state_t;

  // command word from controller to datapath
  typedef struct packed {
    logic load;        // capture residue and modulus, start reduce division
    logic sqrt_start;  // start integer square root
    logic euc_start;   // start division r0 / r1
    logic euc_update;  // apply quotient to r and t
    logic sign_fix;    // normalize sign, compute checks
    logic gcd_init;    // load gcd operands
    logic gcd_start;   // start gcd division
    logic gcd_update;  // shift gcd pair
    logic mul_start;   // start modular multiply
  } dp_cmd_t;

  typedef struct packed {
    logic mod_small;   // modulus below two
    logic div_busy;
    logic sqrt_busy;
    logic mul_busy;
    logic euc_done;    // |r1| <= bound
    logic cand_bad;    // d == 0 or a part exceeds bound
    logic gcd_zero;    // second gcd operand is zero
    logic gcd_one;     // first gcd operand is one
    logic verify_ok;
  } dp_stat_t;

endpackage

// ===== rtl/rr_divider.sv =====
// unsigned restoring divider, one quotient bit per cycle
// depends on rr_pkg
`timescale 1ns / 1ps

module rr_divider
  import rr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              busy,
  output logic [WORD_W-1:0] quotient,
  output logic [WORD_W-1:0] remainder
);

  logic [6:0]        count;
  logic [WORD_W-1:0] dvs;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   shifted;

  assign shifted = {remainder, quotient[WORD_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      count     <= 7'(WORD_W);
      dvs       <= divisor;
      quotient  <= dividend;
      remainder <= '0;
    end else if (busy) begin
      if (trial[WORD_W]) begin
        remainder <= shifted[WORD_W-1:0];
        quotient  <= {quotient[WORD_W-2:0], 1'b0};
      end else begin
        remainder <= trial[WORD_W-1:0];
        quotient  <= {quotient[WORD_W-2:0], 1'b1};
      end
      count <= count - 7'd1;
      if (count == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rr_datapath.sv =====
// datapath: reduction, square root, extended euclid, gcd and modular check
// depends on rr_pkg and rr_divider
`timescale 1ns / 1ps

module rr_datapath
  import rr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  input  logic [WORD_W-1:0] residue,
  input  logic [WORD_W-1:0] modulus,
  output dp_stat_t          stat,
  output logic [NUM_W-1:0]  numerator,
  output logic [DEN_W-1:0]  denominator
);

  logic [WORD_W-1:0] m, rm, bound;
  logic signed [WORD_W-1:0] r0, r1, t0, t1;
  logic signed [WORD_W-1:0] num, den;
  logic [WORD_W-1:0] ga, gb;
  logic              r0_neg, r1_neg;
  logic              neg_q;

  // shared divider
  logic              div_start, div_busy;
  logic [WORD_W-1:0] div_a, div_b, div_q, div_r;

  rr_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_r)
  );

  function automatic logic [WORD_W-1:0] mag(input logic signed [WORD_W-1:0] v);
    mag = v[WORD_W-1] ? (~v + 64'd1) : v;
  endfunction

  always_comb begin
    div_start = cmd.load | cmd.euc_start | cmd.gcd_start;
    div_a     = residue;
    div_b     = modulus;
    if (cmd.euc_start) begin
      div_a = mag(r0);
      div_b = mag(r1);
    end else if (cmd.gcd_start) begin
      div_a = ga;
      div_b = gb;
    end
  end

  // truncating signed quotient and remainder of r0 / r1
  logic signed [WORD_W-1:0] q_s, rem_s;
  assign q_s   = (r0_neg ^ r1_neg) ? (~div_q + 64'd1) : div_q;
  assign rem_s = r0_neg ? (~div_r + 64'd1) : div_r;

  // quotient times t1 from 32x32 partial products: low part, then the two upper cross terms
  logic [1:0]               mq_phase;
  logic [WORD_W-1:0]        prod_acc;
  logic signed [WORD_W-1:0] q_hold, rem_hold;
  logic [31:0]              mq_a, mq_b;
  logic [WORD_W-1:0]        mq_p;
  assign mq_p = mq_a * mq_b;

  // isqrt state
  logic              sq_busy;
  logic [WORD_W-1:0] sq_x, sq_res, sq_bit;

  // modular multiply rm * den, one bit a cycle
  logic              mm_busy;
  logic [WORD_W-1:0] mm_x, mm_acc;
  logic [DEN_W-1:0]  mm_y;
  logic [WORD_W:0]   mm_s1, mm_s2;
  assign mm_s1 = {1'b0, mm_acc} + {1'b0, mm_x};
  assign mm_s2 = {1'b0, mm_x} + {1'b0, mm_x};

  logic [WORD_W-1:0] abs_num, nmod;
  assign abs_num = mag(num);
  assign nmod    = num[WORD_W-1] ? (m - abs_num) : num;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy  <= 1'b0;
      mm_busy  <= 1'b0;
      mq_phase <= '0;
    end else begin
      if (cmd.load) begin
        m <= modulus;
      end
      if (cmd.sqrt_start) begin
        // reduce result is ready; set up symmetric r1 and root search
        rm     <= div_r;
        r0     <= m;
        r0_neg <= 1'b0;
        t0     <= '0;
        t1     <= 64'sd1;
        if (div_r > (m >> 1)) begin
          r1     <= ~(m - div_r) + 64'd1;
          r1_neg <= 1'b1;
        end else begin
          r1     <= div_r;
          r1_neg <= 1'b0;
        end
        sq_x    <= m >> 1;
        sq_res  <= '0;
        sq_bit  <= 64'h4000_0000_0000_0000;
        sq_busy <= 1'b1;
      end else if (sq_busy) begin
        if (sq_x >= sq_res + sq_bit) begin
          sq_x   <= sq_x - (sq_res + sq_bit);
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
        if (sq_bit == 64'd1) begin
          sq_busy <= 1'b0;
          bound   <= (sq_x >= sq_res + sq_bit) ? ((sq_res >> 1) + sq_bit) : (sq_res >> 1);
        end
      end
      if (cmd.euc_update) begin
        q_hold   <= q_s;
        rem_hold <= rem_s;
        mq_a     <= q_s[31:0];
        mq_b     <= t1[31:0];
        mq_phase <= 2'd1;
      end else if (mq_phase == 2'd1) begin
        // low part; the upper cross terms follow
        prod_acc <= mq_p;
        mq_a     <= q_hold[63:32];
        mq_b     <= t1[31:0];
        mq_phase <= 2'd2;
      end else if (mq_phase == 2'd2) begin
        prod_acc <= prod_acc + {mq_p[31:0], 32'd0};
        mq_a     <= q_hold[31:0];
        mq_b     <= t1[63:32];
        mq_phase <= 2'd3;
      end else if (mq_phase == 2'd3) begin
        r0       <= r1;
        r0_neg   <= r1_neg;
        r1       <= rem_hold;
        r1_neg   <= rem_hold[WORD_W-1];
        t0       <= t1;
        t1       <= t0 - $signed(prod_acc + {mq_p[31:0], 32'd0});
        mq_phase <= 2'd0;
      end
      if (cmd.sign_fix) begin
        if (t1[WORD_W-1]) begin
          num <= ~r1 + 64'd1;
          den <= ~t1 + 64'd1;
        end else begin
          num <= r1;
          den <= t1;
        end
      end
      if (cmd.gcd_init) begin
        ga <= abs_num;
        gb <= den;
      end else if (cmd.gcd_update) begin
        ga <= gb;
        gb <= div_r;
      end
      if (cmd.mul_start) begin
        mm_busy <= 1'b1;
        mm_acc  <= '0;
        mm_x    <= rm;
        mm_y    <= den[DEN_W-1:0];
      end else if (mm_busy) begin
        if (mm_y[0]) begin
          mm_acc <= (mm_s1 >= {1'b0, m}) ? WORD_W'(mm_s1 - {1'b0, m}) : mm_s1[WORD_W-1:0];
        end
        mm_x <= (mm_s2 >= {1'b0, m}) ? WORD_W'(mm_s2 - {1'b0, m}) : mm_s2[WORD_W-1:0];
        mm_y <= mm_y >> 1;
        if (mm_y == '0) begin
          mm_busy <= 1'b0;
        end
      end
    end
  end

  assign neg_q = 1'b0;

  always_comb begin
    stat.mod_small = (m < 64'd2);
    stat.div_busy  = div_busy | (mq_phase != 2'd0) | neg_q;
    stat.sqrt_busy = sq_busy;
    stat.mul_busy  = mm_busy;
    stat.euc_done  = (mag(r1) <= bound);
    stat.cand_bad  = (den == '0) || (abs_num > bound) || (den > bound);
    stat.gcd_zero  = (gb == '0);
    stat.gcd_one   = (ga == 64'd1);
    // nmod - prod == 0 mod m, both already below m
    stat.verify_ok = (nmod == mm_acc);
  end

  assign numerator   = num[NUM_W-1:0];
  assign denominator = den[DEN_W-1:0];

endmodule

// ===== rtl/rr_controller.sv =====
// controller state machine sequencing the datapath
// depends on rr_pkg
`timescale 1ns / 1ps

module rr_controller
  import rr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_req,
  input  dp_stat_t          stat,
  input  logic              out_taken,
  output logic              idle,
  output dp_cmd_t           cmd,
  output logic              out_load,
  output logic [STAT_W-1:0] out_status
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    out_load   = 1'b0;
    out_status = STAT_NOFRAC;
    idle       = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_req) begin
          cmd.load   = 1'b1;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (stat.mod_small) begin
          if (out_taken) begin
            out_load   = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (!stat.div_busy) begin
          cmd.sqrt_start = 1'b1;
          state_next     = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (!stat.sqrt_busy) begin
          state_next = ST_EUCLID_CHK;
        end
      end
      ST_EUCLID_CHK: begin
        if (!stat.div_busy) begin
          if (stat.euc_done) begin
            cmd.sign_fix = 1'b1;
            state_next   = ST_SIGN;
          end else begin
            cmd.euc_start = 1'b1;
            state_next    = ST_EUCLID_DIV;
          end
        end
      end
      ST_EUCLID_DIV: begin
        if (!stat.div_busy) begin
          cmd.euc_update = 1'b1;
          state_next     = ST_EUCLID_CHK;
        end
      end
      ST_SIGN: begin
        if (stat.cand_bad) begin
          state_next = ST_OUT;
        end else begin
          cmd.gcd_init = 1'b1;
          state_next   = ST_GCD_CHK;
        end
      end
      ST_GCD_CHK: begin
        if (stat.gcd_zero) begin
          if (stat.gcd_one) begin
            cmd.mul_start = 1'b1;
            state_next    = ST_MUL;
          end else begin
            state_next = ST_OUT;
          end
        end else begin
          cmd.gcd_start = 1'b1;
          state_next    = ST_GCD_DIV;
        end
      end
      ST_GCD_DIV: begin
        if (!stat.div_busy) begin
          cmd.gcd_update = 1'b1;
          state_next     = ST_GCD_CHK;
        end
      end
      ST_MUL: begin
        if (!stat.mul_busy) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        out_status = stat.verify_ok ? STAT_OK : STAT_VERIFY;
        if (out_taken) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_taken) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/rational_reconstruction_unit.sv =====
// rational reconstruction unit: top level with config register and output register
// depends on rr_pkg, rr_controller, rr_datapath
// the reduction and every euclid and gcd step each run the shared divider; the square root and the
// modular multiply run in their own datapath units; a modulus below two goes straight to the output
// throughput: one request at a time; reset: synchronous, modulus 2, controller idle, output empty
`timescale 1ns / 1ps

module rational_reconstruction_unit
  import rr_pkg::*;
#(
  parameter int unsigned MOD_WIDTH = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [WORD_W-1:0]    pwdata,
  output logic [WORD_W-1:0]    prdata,
  output logic                 pready,
  input  logic                 valid,
  output logic                 ready,
  input  logic [WORD_W-1:0]    residue,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic signed [NUM_W-1:0] numerator,
  output logic [DEN_W-1:0]     denominator,
  output logic [STAT_W-1:0]    status
);

  logic [MOD_WIDTH-1:0] modulus;
  logic                 wr;
  logic                 ctl_idle, out_load, out_taken;
  logic [STAT_W-1:0]    out_status;
  dp_cmd_t              cmd;
  dp_stat_t             stat;
  logic [NUM_W-1:0]     dp_num;
  logic [DEN_W-1:0]     dp_den;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;

  // modulus register, MOD_WIDTH bits (63 by default) at address 0
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_WIDTH'(2);
    end else if (wr) begin
      if (paddr == ADDR_MODULUS) begin
        modulus <= pwdata[MOD_WIDTH-1:0];
      end
    end
  end

  assign prdata = WORD_W'(modulus);

  assign ready     = ctl_idle;
  assign out_taken = !result_valid || result_ready;

  rr_controller u_ctl (
    .clk        (clk),
    .rst        (rst),
    .in_req     (valid),
    .stat       (stat),
    .out_taken  (out_taken),
    .idle       (ctl_idle),
    .cmd        (cmd),
    .out_load   (out_load),
    .out_status (out_status)
  );

  rr_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .residue     (residue),
    .modulus     (WORD_W'(modulus)),
    .stat        (stat),
    .numerator   (dp_num),
    .denominator (dp_den)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
      status       <= out_status;
      numerator    <= (out_status == STAT_OK) ? dp_num : '0;
      denominator  <= (out_status == STAT_OK) ? dp_den : '0;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    (valid && ready) |=> !ready)
    else $error("accepted a second request while busy");

  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status == STAT_OK) |-> (denominator != '0))
    else $error("success with zero denominator");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status != STAT_OK) |-> (numerator == '0 && denominator == '0))
    else $error("failure result not cleared");

endmodule
